// ----- sv/ssm_pkg.sv -----
// Shared types and constants for the sorted set merge block.
`default_nettype none
package ssm_pkg;

  localparam int ID_PORT_W      = 32;
  localparam int LIST_DEPTH_DEF = 32;
  localparam int ID_WIDTH_DEF   = 32;
  localparam int QUEUE_DEPTH    = 2;

  // func codes on the input port
  localparam logic [1:0] FUNC_PUSH_FIRST  = 2'd0;
  localparam logic [1:0] FUNC_PUSH_SECOND = 2'd1;
  localparam logic [1:0] FUNC_RUN         = 2'd2;

  // set_mask bits
  localparam logic [2:0] KEEP_FIRST  = 3'b001;
  localparam logic [2:0] KEEP_SECOND = 3'b010;
  localparam logic [2:0] KEEP_COMMON = 3'b100;
  localparam logic [2:0] MASK_RESET  = 3'b111;

  typedef enum logic [1:0] {
    OP_PUSH_FIRST,
    OP_PUSH_SECOND,
    OP_RUN
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_t;

endpackage
`default_nettype wire

// ----- sv/sorted_set_merge_op.sv -----
// Top level of the sorted set merge block: front end, command queue and back end.
//
//  channel | ports                                            | handshake
//  --------+--------------------------------------------------+---------------------------
//  input   | in_func, in_item_id                              | taken when start && !busy
//  result  | out_result_id, out_last, out_empty_res, out_overflow | out_valid, one cycle
//  config  | cfg_wdata (set_mask)                             | written when cfg_we
//
//  A push is done by the back end in S_IDLE; a run leaves the queue in S_IDLE, then
//  does its merge steps in S_RUN (between max(n1,n2) and n1+n2 steps) and its final item in S_FLUSH.
//  Items wait in a two-entry command queue; busy is high while it is full.
//  rst_n is synchronous: counts, flags and the queue are emptied, set_mask goes to 7.
//  Results leave on a one-cycle strobe and cannot be held off.
`default_nettype none
module sorted_set_merge_op #(
  parameter int LIST_DEPTH = ssm_pkg::LIST_DEPTH_DEF,
  parameter int ID_WIDTH   = ssm_pkg::ID_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [ssm_pkg::ID_PORT_W-1:0]  in_item_id,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_wdata,
  output logic                           out_valid,
  output logic [ssm_pkg::ID_PORT_W-1:0]  out_result_id,
  output logic                           out_last,
  output logic                           out_empty_res,
  output logic                           out_overflow
);
  import ssm_pkg::*;

  // ids are held in the low bits that fit both ID_WIDTH and the port
  localparam int SW = (ID_WIDTH < ID_PORT_W) ? ID_WIDTH : ID_PORT_W;

  cmd_t          q_head;
  logic [SW-1:0] q_id;
  logic          q_pop;

  ssm_front #(
    .SW (SW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_item_id (in_item_id),
    .q_head     (q_head),
    .q_id       (q_id),
    .q_pop      (q_pop)
  );

  ssm_back #(
    .LIST_DEPTH (LIST_DEPTH),
    .SW         (SW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_head        (q_head),
    .q_id          (q_id),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_result_id (out_result_id),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_overflow  (out_overflow)
  );

endmodule
`default_nettype wire

// ----- sv/ssm_front.sv -----
// Front end: accepts items, decodes func and queues commands for the back end.
`default_nettype none
module ssm_front #(
  parameter int SW = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [ssm_pkg::ID_PORT_W-1:0]  in_item_id,
  output ssm_pkg::cmd_t                  q_head,
  output logic [SW-1:0]                  q_id,
  input  logic                           q_pop
);
  import ssm_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);
  localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);

  op_t             op_q   [QUEUE_DEPTH];
  logic [SW-1:0]   id_q   [QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  cnt_r, cnt_nxt;
  logic            acc;
  logic            push;
  logic            pop;
  op_t             dec_op;
  logic            dec_ok;

  assign busy = (cnt_r == QFULL);
  assign acc  = start && !busy;

  // func 3 is accepted and dropped
  always_comb begin
    dec_op = OP_RUN;
    dec_ok = 1'b1;
    case (in_func)
      FUNC_PUSH_FIRST:  dec_op = OP_PUSH_FIRST;
      FUNC_PUSH_SECOND: dec_op = OP_PUSH_SECOND;
      FUNC_RUN:         dec_op = OP_RUN;
      default:          dec_ok = 1'b0;
    endcase
  end

  assign push = acc && dec_ok;
  assign pop  = q_pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QLAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QLAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wr_ptr_r] <= dec_op;
      id_q[wr_ptr_r] <= in_item_id[SW-1:0];
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.op    = op_q[rd_ptr_r];
  assign q_id         = id_q[rd_ptr_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QFULL)
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QFULL) && !q_pop |=> cnt_r == QFULL)
    else $error("queue lost an entry while full");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule
`default_nettype wire

// ----- sv/ssm_back.sv -----
// Back end: list stores, counts, mask register and the merge sequencer.
`default_nettype none
module ssm_back #(
  parameter int LIST_DEPTH = 32,
  parameter int SW         = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_wdata,
  input  ssm_pkg::cmd_t                  q_head,
  input  logic [SW-1:0]                  q_id,
  output logic                           q_pop,
  output logic                           out_valid,
  output logic [ssm_pkg::ID_PORT_W-1:0]  out_result_id,
  output logic                           out_last,
  output logic                           out_empty_res,
  output logic                           out_overflow
);
  import ssm_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  logic [SW-1:0] mem1 [LIST_DEPTH];
  logic [SW-1:0] mem2 [LIST_DEPTH];

  state_t        st_r, st_nxt;
  logic [CW-1:0] c1_r, c1_nxt, c2_r, c2_nxt;
  logic [CW-1:0] i1_r, i1_nxt, i2_r, i2_nxt;
  logic [SW-1:0] rd1_r, rd2_r;
  logic [2:0]    mask_r;
  logic          drop_r, drop_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [SW-1:0] pend_id_r, pend_id_nxt;
  logic          out_v_r, out_v_nxt;
  logic [SW-1:0] out_id_r, out_id_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_empty_r, out_empty_nxt;
  logic          out_ovf_r;
  logic          wr1, wr2;
  logic          has1, has2, take1, take2, keep;
  logic [SW-1:0] val;

  // one merge step on the current heads
  always_comb begin
    has1  = (i1_r < c1_r);
    has2  = (i2_r < c2_r);
    take1 = 1'b0;
    take2 = 1'b0;
    keep  = 1'b0;
    val   = rd1_r;
    if (!has1) begin
      take2 = has2;
      keep  = has2 && ((mask_r & KEEP_SECOND) != '0);
      val   = rd2_r;
    end else if (!has2) begin
      take1 = 1'b1;
      keep  = (mask_r & KEEP_FIRST) != '0;
    end else if (rd1_r < rd2_r) begin
      take1 = 1'b1;
      keep  = (mask_r & KEEP_FIRST) != '0;
    end else if (rd2_r < rd1_r) begin
      take2 = 1'b1;
      keep  = (mask_r & KEEP_SECOND) != '0;
      val   = rd2_r;
    end else begin
      take1 = 1'b1;
      take2 = 1'b1;
      keep  = (mask_r & KEEP_COMMON) != '0;
    end
  end

  // a kept id is held back one step so that the final one can carry last
  always_comb begin
    st_nxt        = st_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    i1_nxt        = i1_r;
    i2_nxt        = i2_r;
    drop_nxt      = drop_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    out_v_nxt     = 1'b0;
    out_id_nxt    = pend_id_r;
    out_last_nxt  = 1'b0;
    out_empty_nxt = 1'b0;
    q_pop         = 1'b0;
    wr1           = 1'b0;
    wr2           = 1'b0;
    case (st_r)
      S_IDLE: begin
        i1_nxt = '0;
        i2_nxt = '0;
        if (q_head.valid) begin
          q_pop = 1'b1;
          case (q_head.op)
            OP_PUSH_FIRST: begin
              if (c1_r < DEPTH_C) begin
                wr1    = 1'b1;
                c1_nxt = c1_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            OP_PUSH_SECOND: begin
              if (c2_r < DEPTH_C) begin
                wr2    = 1'b1;
                c2_nxt = c2_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            OP_RUN: begin
              pend_v_nxt = 1'b0;
              st_nxt     = ((c1_r == '0) && (c2_r == '0)) ? S_FLUSH : S_RUN;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        i1_nxt = i1_r + CW'(take1);
        i2_nxt = i2_r + CW'(take2);
        if (keep) begin
          out_v_nxt   = pend_v_r;
          pend_v_nxt  = 1'b1;
          pend_id_nxt = val;
        end
        if ((i1_nxt >= c1_r) && (i2_nxt >= c2_r)) begin
          st_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        out_v_nxt    = 1'b1;
        out_last_nxt = 1'b1;
        if (!pend_v_r) begin
          out_id_nxt    = '0;
          out_empty_nxt = 1'b1;
        end
        c1_nxt   = '0;
        c2_nxt   = '0;
        drop_nxt = 1'b0;
        st_nxt   = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r       <= '0;
      c2_r       <= '0;
      i1_r       <= '0;
      i2_r       <= '0;
      drop_r     <= 1'b0;
      pend_v_r   <= 1'b0;
      mask_r     <= MASK_RESET;
      out_v_r    <= 1'b0;
      out_last_r <= 1'b0;
      out_empty_r <= 1'b0;
    end else begin
      c1_r       <= c1_nxt;
      c2_r       <= c2_nxt;
      i1_r       <= i1_nxt;
      i2_r       <= i2_nxt;
      drop_r     <= drop_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
      out_last_r <= out_last_nxt;
      out_empty_r <= out_empty_nxt;
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    out_id_r  <= out_id_nxt;
    out_ovf_r <= drop_r;
  end

  // heads are registered from the next indices, so they line up with i1_r and i2_r
  always_ff @(posedge clk) begin
    if (wr1) begin
      mem1[c1_r[AW-1:0]] <= q_id;
    end
    rd1_r <= mem1[i1_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr2) begin
      mem2[c2_r[AW-1:0]] <= q_id;
    end
    rd2_r <= mem2[i2_nxt[AW-1:0]];
  end

  assign out_valid     = out_v_r;
  assign out_result_id = ID_PORT_W'(out_id_r);
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;
  assign out_overflow  = out_ovf_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_last_r |-> (c1_r == '0) && (c2_r == '0) && !drop_r)
    else $error("stores not emptied with final item");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_empty_r |-> out_last_r)
    else $error("empty item without last");

  a_run_work: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_RUN |-> (i1_r < c1_r) || (i2_r < c2_r))
    else $error("merge step with both lists exhausted");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (c1_r <= DEPTH_C) && (c2_r <= DEPTH_C))
    else $error("list count beyond depth");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !wr1 && !wr2)
    else $error("store written during a run");

endmodule
`default_nettype wire
